@@ hw/rtl/dcsc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package dcsc_pkg;

    localparam int unsigned MAX_FRAME_BYTES = 65536;
    localparam int unsigned FRAME_W         = 17;
    localparam int unsigned TICK_W          = 32;
    localparam int unsigned IN_DATA_W       = 128;
    localparam int unsigned OUT_DATA_W      = 112;
    localparam int unsigned CFG_ADDR_W      = 1;
    localparam int unsigned CFG_DATA_W      = 32;

    localparam logic [TICK_W-1:0] HALF_RANGE      = 32'h7FFF_FFFF;
    localparam logic [FRAME_W-1:0] FRAME_RESET    = 17'd4096;
    localparam logic [TICK_W-1:0] TIMEOUT_RESET   = 32'd1000000;
    localparam logic [FRAME_W-1:0] FRAME_MAX      = FRAME_W'(MAX_FRAME_BYTES);

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_FRAME_BYTES = 1'b0,
        REG_TICK_LIMIT  = 1'b1
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_IDLE      = 2'd0,
        MODE_CAPTURING = 2'd1,
        MODE_READY     = 2'd2,
        MODE_FAULT     = 2'd3
    } mode_t;

    typedef enum logic [3:0] {
        FAULT_OK        = 4'd0,
        FAULT_CONFIG    = 4'd1,
        FAULT_PREPARE   = 4'd2,
        FAULT_ARM       = 4'd3,
        FAULT_TRIGGER   = 4'd4,
        FAULT_DMA_ERROR = 4'd5,
        FAULT_OVERFLOW  = 4'd6,
        FAULT_LENGTH    = 4'd7,
        FAULT_TIMEOUT   = 4'd8,
        FAULT_FINISH    = 4'd9,
        FAULT_CANCELLED = 4'd10
    } fault_t;

    typedef enum logic [2:0] {
        CMD_START   = 3'd0,
        CMD_EVENT   = 3'd1,
        CMD_POLL    = 3'd2,
        CMD_CANCEL  = 3'd3,
        CMD_RELEASE = 3'd4
    } cmd_t;

    // packed from MSB down, so the last member lands in bit 0
    typedef struct packed {
        logic              frame_available;
        logic              dma_owns_buffer;
        logic              overflow_checked_out;
        logic [TICK_W-1:0] done_tick_out;
        logic [TICK_W-1:0] start_tick_out;
        logic [TICK_W-1:0] generation_out;
        logic [3:0]        fault_code;
        logic [1:0]        session_state;
        logic              accepted;
    } result_t;

    localparam int unsigned RESULT_W = $bits(result_t);

endpackage

`default_nettype wire

@@ hw/rtl/dma_capture_session_controller_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// An accepted request updates the session and registers its result in a single pass.
// Throughput: one request per cycle while the skid entry is empty.
// A two-entry output stage (result register plus skid) keeps s_axis_tready high
// while one result is stalled.
// Reset (aresetn low, synchronous): session idle, fault ok, counters and ticks zero,
// frame_bytes 4096, tick limit 1000000, output stage empty.

module dma_capture_session_controller_core (
    input  wire logic                                    aclk,
    input  wire logic                                    aresetn,
    // config write port
    input  wire logic                                    cfg_we,
    input  wire logic [dcsc_pkg::CFG_ADDR_W-1:0]         cfg_addr,
    input  wire logic [dcsc_pkg::CFG_DATA_W-1:0]         cfg_wdata,
    // request channel
    input  wire logic                                    s_axis_tvalid,
    output logic                                         s_axis_tready,
    // now[31:0], prepare_ok[32], arm_ok[33], trigger_ok[34], finish_ok[35],
    // abort_ok[36], event_generation[68:37], event_flags[71:69],
    // event_tick[103:72], event_bytes[120:104], event_overflow_seen[121], zero pad
    input  wire logic [dcsc_pkg::IN_DATA_W-1:0]          s_axis_tdata,
    // command[2:0]
    input  wire logic [2:0]                              s_axis_tuser,
    // result channel
    output logic                                         m_axis_tvalid,
    input  wire logic                                    m_axis_tready,
    // accepted[0], session_state[2:1], fault_code[6:3], generation_out[38:7],
    // start_tick_out[70:39], done_tick_out[102:71], overflow_checked_out[103],
    // dma_owns_buffer[104], frame_available[105], zero pad
    output logic [dcsc_pkg::OUT_DATA_W-1:0]              m_axis_tdata
);

    // configuration
    logic [dcsc_pkg::FRAME_W-1:0] frame_bytes_reg;
    logic [dcsc_pkg::TICK_W-1:0]  tick_limit_reg;

    // session state
    dcsc_pkg::mode_t              mode_reg, mode_next;
    dcsc_pkg::fault_t             fault_reg, fault_next;
    logic [dcsc_pkg::TICK_W-1:0]  gen_reg, gen_next;
    logic [dcsc_pkg::TICK_W-1:0]  start_tick_reg, start_tick_next;
    logic [dcsc_pkg::TICK_W-1:0]  done_tick_reg, done_tick_next;
    logic                         ovf_checked_reg, ovf_checked_next;
    logic                         dma_owned_reg, dma_owned_next;
    logic                         accepted_next;

    // output stage
    logic                         out_valid_reg, skid_valid_reg;
    dcsc_pkg::result_t            out_data_reg, skid_data_reg;
    dcsc_pkg::result_t            result_next;

    // unpacked request
    logic [2:0]                   command;
    logic [dcsc_pkg::TICK_W-1:0]  now;
    logic                         prepare_ok, arm_ok, trigger_ok, finish_ok, abort_ok;
    logic [dcsc_pkg::TICK_W-1:0]  event_generation;
    logic [2:0]                   event_flags;
    logic [dcsc_pkg::TICK_W-1:0]  event_tick;
    logic [dcsc_pkg::FRAME_W-1:0] event_bytes;
    logic                         event_overflow_seen;

    logic                         in_fire, out_fire;
    logic                         cfg_ok;
    logic [dcsc_pkg::TICK_W-1:0]  since_start, event_age, report_lag;
    logic                         timed_out, event_late;

    assign command             = s_axis_tuser;
    assign now                 = s_axis_tdata[31:0];
    assign prepare_ok          = s_axis_tdata[32];
    assign arm_ok              = s_axis_tdata[33];
    assign trigger_ok          = s_axis_tdata[34];
    assign finish_ok           = s_axis_tdata[35];
    assign abort_ok            = s_axis_tdata[36];
    assign event_generation    = s_axis_tdata[68:37];
    assign event_flags         = s_axis_tdata[71:69];
    assign event_tick          = s_axis_tdata[103:72];
    assign event_bytes         = s_axis_tdata[120:104];
    assign event_overflow_seen = s_axis_tdata[121];

    assign s_axis_tready = !skid_valid_reg;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign out_fire      = out_valid_reg && m_axis_tready;
    assign m_axis_tdata  = {{(dcsc_pkg::OUT_DATA_W - dcsc_pkg::RESULT_W){1'b0}}, out_data_reg};

    assign cfg_ok = (frame_bytes_reg != '0) && (frame_bytes_reg <= dcsc_pkg::FRAME_MAX)
                 && (frame_bytes_reg[1:0] == 2'b00)
                 && (tick_limit_reg != '0)
                 && (tick_limit_reg <= dcsc_pkg::HALF_RANGE);

    // wrap-safe tick differences
    assign since_start = now - start_tick_reg;
    assign event_age   = event_tick - start_tick_reg;
    assign report_lag  = now - event_tick;
    assign timed_out   = since_start >= tick_limit_reg;
    assign event_late  = timed_out || (event_age >= tick_limit_reg)
                      || (report_lag > dcsc_pkg::HALF_RANGE);

    always_comb begin
        mode_next        = mode_reg;
        fault_next       = fault_reg;
        gen_next         = gen_reg;
        start_tick_next  = start_tick_reg;
        done_tick_next   = done_tick_reg;
        ovf_checked_next = ovf_checked_reg;
        dma_owned_next   = dma_owned_reg;
        accepted_next    = 1'b0;

        case (command)
            dcsc_pkg::CMD_START: begin
                if (mode_reg == dcsc_pkg::MODE_IDLE) begin
                    if (!cfg_ok) begin
                        mode_next  = dcsc_pkg::MODE_FAULT;
                        fault_next = dcsc_pkg::FAULT_CONFIG;
                        if (abort_ok) begin
                            dma_owned_next = 1'b0;
                        end
                    end else begin
                        start_tick_next  = now;
                        ovf_checked_next = 1'b0;
                        gen_next         = gen_reg + 1'b1;
                        if (!prepare_ok) begin
                            mode_next  = dcsc_pkg::MODE_FAULT;
                            fault_next = dcsc_pkg::FAULT_PREPARE;
                            if (abort_ok) begin
                                dma_owned_next = 1'b0;
                            end
                        end else if (!arm_ok || !trigger_ok) begin
                            // DMA was handed the buffer, so the abort outcome decides
                            mode_next      = dcsc_pkg::MODE_FAULT;
                            fault_next     = !arm_ok ? dcsc_pkg::FAULT_ARM
                                                     : dcsc_pkg::FAULT_TRIGGER;
                            dma_owned_next = !abort_ok;
                        end else begin
                            mode_next      = dcsc_pkg::MODE_CAPTURING;
                            dma_owned_next = 1'b1;
                            accepted_next  = 1'b1;
                        end
                    end
                end
            end
            dcsc_pkg::CMD_EVENT: begin
                if (mode_reg == dcsc_pkg::MODE_CAPTURING && event_generation == gen_reg
                    && event_flags != 3'b000) begin
                    if (event_flags[0] || event_flags[1] || event_late
                        || event_bytes != frame_bytes_reg || !finish_ok) begin
                        mode_next = dcsc_pkg::MODE_FAULT;
                        if (abort_ok) begin
                            dma_owned_next = 1'b0;
                        end
                        if (event_flags[0]) begin
                            fault_next = dcsc_pkg::FAULT_DMA_ERROR;
                        end else if (event_flags[1]) begin
                            fault_next = dcsc_pkg::FAULT_OVERFLOW;
                        end else if (event_late) begin
                            fault_next = dcsc_pkg::FAULT_TIMEOUT;
                        end else if (event_bytes != frame_bytes_reg) begin
                            fault_next = dcsc_pkg::FAULT_LENGTH;
                        end else begin
                            fault_next = dcsc_pkg::FAULT_FINISH;
                        end
                    end else begin
                        dma_owned_next   = 1'b0;
                        done_tick_next   = event_tick;
                        ovf_checked_next = event_overflow_seen;
                        mode_next        = dcsc_pkg::MODE_READY;
                    end
                end
            end
            dcsc_pkg::CMD_POLL: begin
                if (mode_reg == dcsc_pkg::MODE_CAPTURING && timed_out) begin
                    mode_next  = dcsc_pkg::MODE_FAULT;
                    fault_next = dcsc_pkg::FAULT_TIMEOUT;
                    if (abort_ok) begin
                        dma_owned_next = 1'b0;
                    end
                end
            end
            dcsc_pkg::CMD_CANCEL: begin
                if (mode_reg == dcsc_pkg::MODE_CAPTURING) begin
                    mode_next  = dcsc_pkg::MODE_FAULT;
                    fault_next = dcsc_pkg::FAULT_CANCELLED;
                    if (abort_ok) begin
                        dma_owned_next = 1'b0;
                    end
                end
            end
            dcsc_pkg::CMD_RELEASE: begin
                if (mode_reg == dcsc_pkg::MODE_READY && !dma_owned_reg) begin
                    mode_next     = dcsc_pkg::MODE_IDLE;
                    accepted_next = 1'b1;
                end
            end
            default: begin
                // undefined command codes leave the session untouched
            end
        endcase
    end

    always_comb begin
        result_next.accepted             = accepted_next;
        result_next.session_state        = mode_next;
        result_next.fault_code           = fault_next;
        result_next.generation_out       = gen_next;
        result_next.start_tick_out       = start_tick_next;
        result_next.done_tick_out        = done_tick_next;
        result_next.overflow_checked_out = ovf_checked_next;
        result_next.dma_owns_buffer      = dma_owned_next;
        result_next.frame_available      = (mode_next == dcsc_pkg::MODE_READY)
                                        && !dma_owned_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_bytes_reg <= dcsc_pkg::FRAME_RESET;
            tick_limit_reg  <= dcsc_pkg::TIMEOUT_RESET;
        end else if (cfg_we) begin
            case (cfg_addr)
                dcsc_pkg::REG_FRAME_BYTES: frame_bytes_reg <= cfg_wdata[dcsc_pkg::FRAME_W-1:0];
                dcsc_pkg::REG_TICK_LIMIT:  tick_limit_reg  <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg        <= dcsc_pkg::MODE_IDLE;
            fault_reg       <= dcsc_pkg::FAULT_OK;
            gen_reg         <= '0;
            start_tick_reg  <= '0;
            done_tick_reg   <= '0;
            ovf_checked_reg <= 1'b0;
            dma_owned_reg   <= 1'b0;
        end else if (in_fire) begin
            mode_reg        <= mode_next;
            fault_reg       <= fault_next;
            gen_reg         <= gen_next;
            start_tick_reg  <= start_tick_next;
            done_tick_reg   <= done_tick_next;
            ovf_checked_reg <= ovf_checked_next;
            dma_owned_reg   <= dma_owned_next;
        end
    end

    // result register plus skid entry
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_fire) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            if (out_valid_reg) begin
                skid_valid_reg <= 1'b1;
            end else begin
                out_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (out_fire) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= result_next;
            end
        end else if (in_fire) begin
            if (out_valid_reg) begin
                skid_data_reg <= result_next;
            end else begin
                out_data_reg <= result_next;
            end
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dcsc_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module dcsc_checker (
    input wire logic                              aclk,
    input wire logic                              aresetn,
    input wire logic                              s_axis_tready,
    input wire logic                              m_axis_tvalid,
    input wire logic                              m_axis_tready,
    input wire logic [dcsc_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    logic                 fault_seen_reg;
    logic                 m_fire;
    dcsc_pkg::result_t    res;

    assign m_fire = m_axis_tvalid && m_axis_tready;
    assign res    = dcsc_pkg::result_t'(m_axis_tdata[dcsc_pkg::RESULT_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fault_seen_reg <= 1'b0;
        end else if (m_fire && res.session_state == dcsc_pkg::MODE_FAULT) begin
            fault_seen_reg <= 1'b1;
        end
    end

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // fault is sticky until reset
    a_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        m_fire && fault_seen_reg |-> res.session_state == dcsc_pkg::MODE_FAULT)
        else $error("session left fault without reset");

    // input side only backs up when a result is already pending
    a_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_axis_tready |-> m_axis_tvalid)
        else $error("request stalled with empty result stage");

    a_avail: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res.frame_available |->
            res.session_state == dcsc_pkg::MODE_READY && !res.dma_owns_buffer)
        else $error("frame_available inconsistent with state");

    a_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && res.accepted |->
            res.session_state == dcsc_pkg::MODE_CAPTURING
            || res.session_state == dcsc_pkg::MODE_IDLE)
        else $error("accepted request left an unexpected state");

endmodule

bind dma_capture_session_controller_core dcsc_checker u_dcsc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
